>>> src/sckev_pkg.sv
// Package for the scancode to key event FIFO: event kinds, scancode
// constants, queue sizing and the set-1 ASCII table. No dependencies.
package sckev_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int PTR_W       = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int KIND_W      = 3;
  localparam int CHAR_W      = 7;
  localparam int ENTRY_W     = KIND_W + CHAR_W;

  localparam logic [7:0] SC_CTRL_MAKE  = 8'h1D;
  localparam logic [7:0] SC_CTRL_BREAK = 8'h9D;
  localparam logic [7:0] SC_KEY_C      = 8'h2E;
  localparam logic [7:0] SC_BACKSPACE  = 8'h0E;
  localparam logic [7:0] SC_ENTER      = 8'h1C;
  localparam logic [7:0] TABLE_SIZE    = 8'd58;
  localparam int         BREAK_BIT     = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE      = 3'd0,
    KIND_CHAR      = 3'd1,
    KIND_BACKSPACE = 3'd2,
    KIND_ENTER     = 3'd3,
    KIND_CTRL_C    = 3'd4
  } kind_t;

  typedef struct packed {
    logic              push;
    kind_t             kind;
    logic [CHAR_W-1:0] ch;
  } queue_push_t;

  typedef struct packed {
    kind_t             kind;
    logic [CHAR_W-1:0] ch;
  } read_result_t;

  // Set-1 make code to ASCII; codes 58..63 and unmapped keys give 0.
  function automatic logic [CHAR_W-1:0] ascii_of_code(input logic [5:0] code);
    logic [CHAR_W-1:0] c;
    unique case (code)
      6'd1:  c = 7'h1B;
      6'd2:  c = 7'h31;
      6'd3:  c = 7'h32;
      6'd4:  c = 7'h33;
      6'd5:  c = 7'h34;
      6'd6:  c = 7'h35;
      6'd7:  c = 7'h36;
      6'd8:  c = 7'h37;
      6'd9:  c = 7'h38;
      6'd10: c = 7'h39;
      6'd11: c = 7'h30;
      6'd12: c = 7'h2D;
      6'd13: c = 7'h3D;
      6'd14: c = 7'h08;
      6'd15: c = 7'h09;
      6'd16: c = 7'h71;
      6'd17: c = 7'h77;
      6'd18: c = 7'h65;
      6'd19: c = 7'h72;
      6'd20: c = 7'h74;
      6'd21: c = 7'h79;
      6'd22: c = 7'h75;
      6'd23: c = 7'h69;
      6'd24: c = 7'h6F;
      6'd25: c = 7'h70;
      6'd26: c = 7'h5B;
      6'd27: c = 7'h5D;
      6'd28: c = 7'h0A;
      6'd30: c = 7'h61;
      6'd31: c = 7'h73;
      6'd32: c = 7'h64;
      6'd33: c = 7'h66;
      6'd34: c = 7'h67;
      6'd35: c = 7'h68;
      6'd36: c = 7'h6A;
      6'd37: c = 7'h6B;
      6'd38: c = 7'h6C;
      6'd39: c = 7'h3B;
      6'd40: c = 7'h27;
      6'd41: c = 7'h60;
      6'd43: c = 7'h5C;
      6'd44: c = 7'h7A;
      6'd45: c = 7'h78;
      6'd46: c = 7'h63;
      6'd47: c = 7'h76;
      6'd48: c = 7'h62;
      6'd49: c = 7'h6E;
      6'd50: c = 7'h6D;
      6'd51: c = 7'h2C;
      6'd52: c = 7'h2E;
      6'd53: c = 7'h2F;
      6'd55: c = 7'h2A;
      6'd57: c = 7'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> src/scancode_to_key_event_fifo.sv
// Top level: set-1 scancode decoder feeding a key event queue, read on request.
// Depends on sckev_pkg, sckev_decode, sckev_queue.
//
//   channel | signals                       | payload
//   --------+-------------------------------+-------------------------
//   in      | in_valid, in_ready            | action, scancode
//   out     | out_valid, out_ready          | event_kind, character
//
// One request per cycle while in_ready is high. A scancode request updates
// state at its accept edge and gives no result. A read request loads the
// queue memory read register at its accept edge, and the output register
// loads from it once free or being read out, raising out_valid. in_ready drops
// only while both read stage and output register hold unaccepted results.
// Synchronous reset empties the queue and clears the control flag.
module scancode_to_key_event_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           action,
  input  logic [7:0]                     scancode,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sckev_pkg::KIND_W-1:0]   event_kind,
  output logic [sckev_pkg::CHAR_W-1:0]   character
);
  import sckev_pkg::*;

  logic         accept;
  logic         rd_valid;
  logic         rd_take;
  queue_push_t  key_event;
  read_result_t rd_result;

  assign rd_take  = rd_valid && (!out_valid || out_ready);
  assign in_ready = !rd_valid || rd_take;
  assign accept   = in_valid && in_ready;

  sckev_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .take      (accept && !action),
    .scancode  (scancode),
    .key_event (key_event)
  );

  sckev_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .key_event (key_event),
    .pop       (accept && action),
    .rd_take   (rd_take),
    .rd_valid  (rd_valid),
    .rd_result (rd_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_take) begin
      event_kind <= rd_result.kind;
      character  <= rd_result.ch;
    end
  end

endmodule

>>> src/sckev_decode.sv
// Scancode decoder: control-held flag and mapping of one scancode to a key event.
// Depends on sckev_pkg.
module sckev_decode (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    take,
  input  logic [7:0]              scancode,
  output sckev_pkg::queue_push_t  key_event
);
  import sckev_pkg::*;

  logic control_held;
  logic control_held_next;

  always_comb begin
    control_held_next = control_held;
    key_event.push    = 1'b0;
    key_event.kind    = KIND_NONE;
    key_event.ch      = '0;
    priority if (scancode == SC_CTRL_BREAK) begin
      control_held_next = 1'b0;
    end else if (scancode[BREAK_BIT]) begin
      // other break codes are ignored
    end else if (scancode == SC_CTRL_MAKE) begin
      control_held_next = 1'b1;
    end else if (control_held && scancode == SC_KEY_C) begin
      key_event.push = 1'b1;
      key_event.kind = KIND_CTRL_C;
    end else if (scancode == SC_BACKSPACE) begin
      key_event.push = 1'b1;
      key_event.kind = KIND_BACKSPACE;
    end else if (scancode == SC_ENTER) begin
      key_event.push = 1'b1;
      key_event.kind = KIND_ENTER;
    end else if (scancode < TABLE_SIZE) begin
      key_event.ch   = ascii_of_code(scancode[5:0]);
      key_event.push = (key_event.ch != '0);
      key_event.kind = key_event.push ? KIND_CHAR : KIND_NONE;
    end else begin
      // make codes past the table give no event
    end
    if (!take) begin
      control_held_next = control_held;
      key_event.push    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_held <= 1'b0;
    end else begin
      control_held <= control_held_next;
    end
  end

endmodule

>>> src/sckev_queue.sv
// Ring event queue (holds depth minus one) with a registered read stage.
// Depends on sckev_pkg.
module sckev_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  sckev_pkg::queue_push_t    key_event,
  input  logic                      pop,
  input  logic                      rd_take,
  output logic                      rd_valid,
  output sckev_pkg::read_result_t   rd_result
);
  import sckev_pkg::*;

  logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   write_pointer;
  logic [PTR_W-1:0]   read_pointer;
  logic [PTR_W-1:0]   wp_inc;
  logic [PTR_W-1:0]   rp_inc;
  logic               empty;
  logic               push_ok;
  logic               pop_ok;
  logic [ENTRY_W-1:0] rd_data;
  logic               rd_empty;

  assign wp_inc  = (write_pointer == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : write_pointer + 1'b1;
  assign rp_inc  = (read_pointer == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : read_pointer + 1'b1;
  assign empty   = (write_pointer == read_pointer);
  assign push_ok = key_event.push && (wp_inc != read_pointer);
  assign pop_ok  = pop && !empty;

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[write_pointer] <= {key_event.kind, key_event.ch};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data <= mem[read_pointer];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      read_pointer  <= '0;
      rd_valid      <= 1'b0;
      rd_empty      <= 1'b0;
    end else begin
      if (push_ok) begin
        write_pointer <= wp_inc;
      end
      if (pop_ok) begin
        read_pointer <= rp_inc;
      end
      if (pop) begin
        rd_valid <= 1'b1;
        rd_empty <= empty;
      end else if (rd_take) begin
        rd_valid <= 1'b0;
      end
    end
  end

  // an empty read answers none/zero
  assign rd_result.kind = rd_empty ? KIND_NONE : kind_t'(rd_data[ENTRY_W-1:CHAR_W]);
  assign rd_result.ch   = rd_empty ? '0 : rd_data[CHAR_W-1:0];

endmodule
